[sv/assert_macros.svh]
// Assertion macros used by the decoder back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define CTD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define CTD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CTD_ASSERT_IMPL(lbl, ante, cons, msg)
`define CTD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[sv/ctd_pkg.sv]
// Types, codes and helpers shared by the CLUT texture decoder.
`timescale 1ns / 1ps
package ctd_pkg;

	localparam int PIX_W  = 22;
	localparam int MODE_W = 3;
	localparam int DATA_W = 16;

	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_PAL   = 2'd1;
	localparam logic [1:0] FUNC_PIX   = 2'd2;
	localparam logic [1:0] FUNC_NONE  = 2'd3;

	localparam logic [MODE_W-1:0] MODE_4BIT   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_8BIT   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_DIRECT = 3'd2;

	localparam logic CFG_PIXEL_MODE   = 1'b0;
	localparam logic CFG_IMAGE_PIXELS = 1'b1;

	// Command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;
	localparam int QCNT_W = 3;
	localparam logic [QCNT_W-1:0] QFULL = 3'd4;

	// Output buffer
	localparam int OUT_DEPTH = 4;
	localparam int OBUF_AW   = 2;
	localparam int OCC_W     = 3;
	localparam logic [OCC_W-1:0] OCC_FULL = 3'd4;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_PAL   = 2'd1,
		KIND_PIX   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		SRC_NIB    = 2'd0,
		SRC_BYTE   = 2'd1,
		SRC_DIRECT = 2'd2,
		SRC_ZERO   = 2'd3
	} src_t;

	typedef struct packed {
		kind_t             kind;
		src_t              src;
		logic [1:0]        npix_m1;
		logic [7:0]        pidx;
		logic [DATA_W-1:0] word;
	} item_t;

	typedef struct packed {
		logic       last;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pixel_t;

	// BGR555 to RGBA8888; only the all-zero word is transparent
	function automatic pixel_t expand(input logic [DATA_W-1:0] w, input logic last);
		pixel_t p;
		p.last  = last;
		p.red   = {w[4:0], 3'b000};
		p.green = {w[9:5], 3'b000};
		p.blue  = {w[14:10], 3'b000};
		p.alpha = (w == '0) ? 8'h00 : 8'hFF;
		return p;
	endfunction

endpackage

[sv/ctd_front.sv]
// Front end: accepts input items, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module ctd_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     func,
	input  logic [7:0]                     palette_index,
	input  logic [ctd_pkg::DATA_W-1:0]     data_word,
	input  logic [ctd_pkg::MODE_W-1:0]     pixel_mode,
	output logic                           q_valid,
	input  logic                           q_ready,
	output ctd_pkg::item_t                 q_item
);

	ctd_pkg::item_t                 entry_q [ctd_pkg::QDEPTH];
	logic [ctd_pkg::QAW-1:0]        wr_ptr_q;
	logic [ctd_pkg::QAW-1:0]        rd_ptr_q;
	logic [ctd_pkg::QCNT_W-1:0]     count_q;
	ctd_pkg::item_t                 cls;
	logic                           xfer_in;
	logic                           push;
	logic                           pop;

	assign in_ready = (count_q != ctd_pkg::QFULL);
	assign xfer_in  = in_valid && in_ready;
	// unused func code is taken and dropped
	assign push     = xfer_in && (func != ctd_pkg::FUNC_NONE);
	assign q_valid  = (count_q != '0);
	assign pop      = q_valid && q_ready;
	assign q_item   = entry_q[rd_ptr_q];

	always_comb begin
		cls.pidx = palette_index;
		cls.word = data_word;
		unique case (func)
			ctd_pkg::FUNC_START: cls.kind = ctd_pkg::KIND_START;
			ctd_pkg::FUNC_PAL:   cls.kind = ctd_pkg::KIND_PAL;
			default:             cls.kind = ctd_pkg::KIND_PIX;
		endcase
		unique case (pixel_mode)
			ctd_pkg::MODE_4BIT: begin
				cls.src     = ctd_pkg::SRC_NIB;
				cls.npix_m1 = 2'd3;
			end
			ctd_pkg::MODE_8BIT: begin
				cls.src     = ctd_pkg::SRC_BYTE;
				cls.npix_m1 = 2'd1;
			end
			ctd_pkg::MODE_DIRECT: begin
				cls.src     = ctd_pkg::SRC_DIRECT;
				cls.npix_m1 = 2'd0;
			end
			default: begin
				cls.src     = ctd_pkg::SRC_ZERO;
				cls.npix_m1 = 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[sv/ctd_back.sv]
// Back end: palette memory, pixel sequencer, lookup and color expansion.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ctd_back #(
	parameter int PALETTE_DEPTH = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_ready,
	input  ctd_pkg::item_t                q_item,
	input  logic [ctd_pkg::PIX_W-1:0]     limit,
	input  logic [ctd_pkg::OCC_W-1:0]     occ,
	output logic                          push,
	output ctd_pkg::pixel_t               push_pix
);

	localparam int AW = $clog2(PALETTE_DEPTH);
	localparam int CW = ctd_pkg::PIX_W;

	logic [ctd_pkg::DATA_W-1:0]  mem [PALETTE_DEPTH];
	logic [PALETTE_DEPTH-1:0]    vbit_q;
	logic [CW-1:0]               cnt_q;
	logic                        loaded_q;
	logic [1:0]                  k_q;

	logic                        valid_s2;
	logic                        lookup_s2;
	logic                        use_s2;
	logic                        last_s2;
	logic [ctd_pkg::DATA_W-1:0]  direct_s2;
	logic [ctd_pkg::DATA_W-1:0]  rd_s2;

	logic                        is_start;
	logic                        is_pal;
	logic                        is_pix;
	logic                        at_limit;
	logic                        space;
	logic                        last_step;
	logic                        issue;
	logic                        pal_we;
	logic                        lookup;
	logic                        inrange;
	logic [7:0]                  raw_idx;
	logic [AW-1:0]               rd_addr;
	logic [CW:0]                 cnt_inc;
	logic [ctd_pkg::DATA_W-1:0]  color;

	always_comb begin
		is_start  = q_valid && (q_item.kind == ctd_pkg::KIND_START);
		is_pal    = q_valid && (q_item.kind == ctd_pkg::KIND_PAL);
		is_pix    = q_valid && (q_item.kind == ctd_pkg::KIND_PIX);
		at_limit  = (cnt_q >= limit);
		cnt_inc   = {1'b0, cnt_q} + 1'b1;
		// leave room for the pixel already in flight
		space     = (({1'b0, occ} + {{ctd_pkg::OCC_W{1'b0}}, valid_s2})
			< {1'b0, ctd_pkg::OCC_FULL});
		last_step = (k_q == q_item.npix_m1) || (cnt_inc == {1'b0, limit});
		issue     = is_pix && !at_limit && space;
		q_ready   = is_start || is_pal || (is_pix && (at_limit || (issue && last_step)));
		pal_we    = is_pal && ({1'b0, q_item.pidx} < 9'(PALETTE_DEPTH));

		unique case (q_item.src)
			ctd_pkg::SRC_NIB:  raw_idx = {4'b0000, q_item.word[{k_q, 2'b00} +: 4]};
			ctd_pkg::SRC_BYTE: raw_idx = q_item.word[{k_q[0], 3'b000} +: 8];
			default:           raw_idx = 8'h00;
		endcase
		lookup  = (q_item.src == ctd_pkg::SRC_NIB) || (q_item.src == ctd_pkg::SRC_BYTE);
		inrange = ({1'b0, raw_idx} < 9'(PALETTE_DEPTH));
		rd_addr = raw_idx[AW-1:0];
	end

	// Palette storage; entries never written read as zero through vbit_q
	always_ff @(posedge clk) begin
		if (pal_we) begin
			mem[q_item.pidx[AW-1:0]] <= q_item.word;
		end
		rd_s2 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			lookup_s2 <= lookup;
			use_s2    <= loaded_q && inrange && vbit_q[rd_addr];
			last_s2   <= last_step;
			direct_s2 <= (q_item.src == ctd_pkg::SRC_DIRECT) ? q_item.word : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbit_q   <= '0;
			cnt_q    <= '0;
			loaded_q <= 1'b0;
			k_q      <= '0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= issue;
			if (pal_we) begin
				vbit_q[q_item.pidx[AW-1:0]] <= 1'b1;
				loaded_q                    <= 1'b1;
			end
			if (is_start) begin
				cnt_q    <= '0;
				loaded_q <= 1'b0;
			end else if (issue) begin
				cnt_q <= cnt_inc[CW-1:0];
			end
			// advance through the word, rewind when it leaves the queue
			if (q_ready) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + 2'd1;
			end
		end
	end

	assign color    = lookup_s2 ? (use_s2 ? rd_s2 : '0) : direct_s2;
	assign push     = valid_s2;
	assign push_pix = ctd_pkg::expand(color, last_s2);

	`CTD_ASSERT_NEXT(a_step_adv, issue && !q_ready, k_q == $past(k_q) + 2'd1, "step did not advance")
	`CTD_ASSERT_IMPL(a_step_rng, is_pix, k_q <= q_item.npix_m1, "step past end of word")
	`CTD_ASSERT_IMPL(a_obuf_room, valid_s2, occ < ctd_pkg::OCC_FULL, "output buffer overrun")
	`CTD_ASSERT_NEXT(a_start_clr, is_start, cnt_q == '0 && !loaded_q, "start did not clear")

endmodule

[sv/ctd_obuf.sv]
// Output buffer holding decoded pixels until the receiver takes them.
`timescale 1ns / 1ps
module ctd_obuf (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  ctd_pkg::pixel_t               push_pix,
	output logic [ctd_pkg::OCC_W-1:0]     occ,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ctd_pkg::pixel_t               head
);

	ctd_pkg::pixel_t                 slot_q [ctd_pkg::OUT_DEPTH];
	logic [ctd_pkg::OBUF_AW-1:0]     wr_ptr_q;
	logic [ctd_pkg::OBUF_AW-1:0]     rd_ptr_q;
	logic [ctd_pkg::OCC_W-1:0]       occ_q;
	logic                            pop;

	assign occ       = occ_q;
	assign out_valid = (occ_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   occ_q <= occ_q + 1'b1;
				2'b01:   occ_q <= occ_q - 1'b1;
				default: occ_q <= occ_q;
			endcase
		end
	end

endmodule

[sv/clut_texture_pixel_decoder.sv]
// Top level of the CLUT texture decoder: configuration registers and block wiring.
//
// Input channel (in_valid/in_ready) carries func, palette_index and data_word.
// func start clears the pixel count and marks the palette unloaded; func palette
// write stores one BGR555 entry; func pixel word yields 4, 2 or 1 RGBA pixels for
// 4-bit, 8-bit or direct mode, and one zero pixel in any other mode. Pixels past
// min(image_pixels, MAX_PIXELS) are dropped; last_of_word marks the final pixel
// returned for a word. Output channel (out_valid/out_ready) carries one pixel
// per transfer. Configuration is written through cfg_we/cfg_index/cfg_data; the user
// must do so only while idle, as the block does not enforce it. A pixel passes through
// the queue entry, the back-end lookup registers and the output buffer slot before it
// is valid. The back-end pixel sequencer, with one palette read per cycle, gives one
// pixel per cycle while the output buffer has room; start and palette items are taken
// as soon as they head the queue. A four-entry queue separates input from the
// sequencer, and a four-entry buffer holds pixels while out_ready is low; input keeps
// flowing until the queue fills. Reset clears the control registers, the queues and
// the palette valid bits, so every palette entry reads as zero with no clearing pass.
`timescale 1ns / 1ps
module clut_texture_pixel_decoder #(
	parameter int PALETTE_DEPTH = 256,
	parameter int MAX_PIXELS    = 2097152
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [ctd_pkg::PIX_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     func,
	input  logic [7:0]                     palette_index,
	input  logic [ctd_pkg::DATA_W-1:0]     data_word,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     red,
	output logic [7:0]                     green,
	output logic [7:0]                     blue,
	output logic [7:0]                     alpha,
	output logic                           last_of_word
);

	localparam logic [ctd_pkg::PIX_W:0] MAX_LIM = (ctd_pkg::PIX_W + 1)'(MAX_PIXELS);

	logic [ctd_pkg::MODE_W-1:0]  pixel_mode_q;
	logic [ctd_pkg::PIX_W-1:0]   limit_q;
	logic                        q_valid;
	logic                        q_ready;
	ctd_pkg::item_t              q_item;
	logic [ctd_pkg::OCC_W-1:0]   occ;
	logic                        push;
	ctd_pkg::pixel_t             push_pix;
	ctd_pkg::pixel_t             head;

	// Keep the clamped pixel limit rather than the raw register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_mode_q <= '0;
			limit_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ctd_pkg::CFG_PIXEL_MODE: pixel_mode_q <= cfg_data[ctd_pkg::MODE_W-1:0];
				default: begin
					if ({1'b0, cfg_data} > MAX_LIM) begin
						limit_q <= MAX_LIM[ctd_pkg::PIX_W-1:0];
					end else begin
						limit_q <= cfg_data;
					end
				end
			endcase
		end
	end

	ctd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.palette_index (palette_index),
		.data_word     (data_word),
		.pixel_mode    (pixel_mode_q),
		.q_valid       (q_valid),
		.q_ready       (q_ready),
		.q_item        (q_item)
	);

	ctd_back #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item),
		.limit    (limit_q),
		.occ      (occ),
		.push     (push),
		.push_pix (push_pix)
	);

	ctd_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_pix  (push_pix),
		.occ       (occ),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign red          = head.red;
	assign green        = head.green;
	assign blue         = head.blue;
	assign alpha        = head.alpha;
	assign last_of_word = head.last;

endmodule
